// ===== sv/sdtq_pkg.sv =====
// Shared types and constants for the sorted deadline timer queue.
// Used by the top level and the divider; depends on nothing.
package sdtq_pkg;

    localparam int unsigned DELAY_W     = 32;
    localparam int unsigned RATE_W      = 17;
    localparam int unsigned PROD_W      = DELAY_W + RATE_W;
    localparam int unsigned REM_W       = 10;
    localparam int unsigned TICK_W      = 64;
    localparam int unsigned HANDLE_W    = 4;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned NEXP_W      = 5;
    localparam int unsigned MS_PER_SEC  = 1000;
    localparam int unsigned MAX_RESULTS = 16;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(100);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NONE      = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT,
        S_MUL, S_DGO, S_DIV, S_SUM, S_ARD, S_AORD, S_ACMP, S_AINS,
        S_RRD, S_RCHK, S_REND,
        S_CHECK, S_TORD, S_TDL, S_FINISH
    } t_state;

endpackage

// ===== sv/sorted_deadline_timer_queue_unit.sv =====
// Top level of the sorted deadline timer queue.
// Depends on sdtq_pkg, sdtq_ram and sdtq_div.
//
// Holds up to SLOTS timers with the deadline order in one RAM and the deadlines
// in another, both memories with registered read data and one read port each, so
// the add walk and the expiry check read the order RAM and then the deadline RAM
// for each entry. An add multiplies the delay by the tick rate, divides by 1000 in
// 17-bit digits and moves each pending timer with a later deadline up one place; a
// delete walks the whole order list and closes the gap; a tick expires the timers
// at the head of the list one by one, each by a delete walk. One beat is worked on
// at a time, and a result waiting at the output holds the block until it is taken.
module sorted_deadline_timer_queue_unit #(
    parameter int unsigned SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,  // tick_rate_hz
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // delay_ms[31:0], target_handle[35:32], zeros
    input  logic [1:0]  i_s_axis_tuser,  // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // result_handle[3:0], current_tick[67:4], zeros
    output logic [2:0]  o_m_axis_tuser,  // status[2:0]
    output logic        o_m_axis_tlast   // last_result
);
    import sdtq_pkg::*;

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);

    t_state r_state, n_state;

    logic [RATE_W-1:0]   r_rate;
    logic [TICK_W-1:0]   r_ctr, n_ctr;
    logic [CW-1:0]       r_count, n_count;
    logic [SLOTS-1:0]    r_in_use, n_in_use;
    logic [CW-1:0]       r_i, n_i;
    logic                r_found, n_found;
    logic [IW-1:0]       r_h, n_h;
    logic [IW-1:0]       r_o, n_o;
    logic [IW-1:0]       r_slot, n_slot;
    logic [IW-1:0]       r_hold, n_hold;
    logic                r_have, n_have;
    logic                r_is_tick, n_is_tick;
    logic [NEXP_W-1:0]   r_nexp, n_nexp;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [TICK_W-1:0]   r_dl, n_dl;
    t_state              r_ret, n_ret;
    t_status             r_pend_st, n_pend_st;
    logic [HANDLE_W-1:0] r_pend_h, n_pend_h;
    logic                r_pend_last, n_pend_last;

    logic                r_out_valid;
    t_status             r_out_st;
    logic [HANDLE_W-1:0] r_out_h;
    logic [TICK_W-1:0]   r_out_tick;
    logic                r_out_last;

    logic                w_accept, w_out_free;
    t_cmd                w_cmd;
    logic [DELAY_W-1:0]  w_delay;
    logic [HANDLE_W-1:0] w_tgt;
    logic [IW-1:0]       w_tgt_idx;
    logic                w_tgt_ok;
    logic                w_any_free;
    logic [IW-1:0]       w_free_idx;
    logic [TICK_W:0]     w_sum;
    logic                w_div_start, w_div_done;
    logic [PROD_W-1:0]   w_quot;

    logic                w_ord_we;
    logic [IW-1:0]       w_ord_waddr, w_ord_wdata, w_ord_raddr, w_ord_rdata;
    logic                w_dl_we;
    logic [IW-1:0]       w_dl_raddr;
    logic [TICK_W-1:0]   w_dl_rdata;

    assign w_cmd      = t_cmd'(i_s_axis_tuser);
    assign w_delay    = i_s_axis_tdata[DELAY_W-1:0];
    assign w_tgt      = i_s_axis_tdata[DELAY_W+HANDLE_W-1:DELAY_W];
    assign w_tgt_idx  = IW'(w_tgt);
    assign w_tgt_ok   = (32'(w_tgt) < 32'(SLOTS)) && r_in_use[w_tgt_idx];
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_sum      = {1'b0, r_ctr} + (TICK_W+1)'(w_quot);
    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        w_any_free = 1'b0;
        w_free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                w_any_free = 1'b1;
                w_free_idx = IW'(k);
            end
        end
    end

    sdtq_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (w_ord_we),
        .i_waddr (w_ord_waddr),
        .i_wdata (w_ord_wdata),
        .i_raddr (w_ord_raddr),
        .o_rdata (w_ord_rdata)
    );

    sdtq_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (w_dl_we),
        .i_waddr (r_slot),
        .i_wdata (n_dl),
        .i_raddr (w_dl_raddr),
        .o_rdata (w_dl_rdata)
    );

    sdtq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_TICK:   n_state = S_CHECK;
                        CMD_ADD:    n_state = w_any_free ? S_MUL : S_EMIT;
                        CMD_DELETE: n_state = w_tgt_ok ? S_RRD : S_EMIT;
                        CMD_NONE:   n_state = S_IDLE;
                    endcase
                end
            end
            S_EMIT:   if (w_out_free) n_state = r_ret;
            S_MUL:    n_state = S_DGO;
            S_DGO:    n_state = S_DIV;
            S_DIV:    if (w_div_done) n_state = S_SUM;
            S_SUM:    n_state = S_ARD;
            S_ARD:    n_state = (r_i == '0) ? S_AINS : S_AORD;
            S_AORD:   n_state = S_ACMP;
            S_ACMP:   n_state = (w_dl_rdata > r_dl) ? S_ARD : S_AINS;
            S_AINS:   n_state = S_EMIT;
            S_RRD:    n_state = (r_i == r_count) ? S_REND : S_RCHK;
            S_RCHK:   n_state = S_RRD;
            S_REND:   n_state = r_is_tick ? S_CHECK : S_EMIT;
            S_CHECK: begin
                if (r_count == '0 || r_nexp == NEXP_W'(MAX_RESULTS)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_TORD;
                end
            end
            S_TORD:   n_state = S_TDL;
            S_TDL: begin
                if (w_dl_rdata <= r_ctr) begin
                    n_state = r_have ? S_EMIT : S_RRD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_ctr       = r_ctr;
        n_count     = r_count;
        n_in_use    = r_in_use;
        n_i         = r_i;
        n_found     = r_found;
        n_h         = r_h;
        n_o         = r_o;
        n_slot      = r_slot;
        n_hold      = r_hold;
        n_have      = r_have;
        n_is_tick   = r_is_tick;
        n_nexp      = r_nexp;
        n_delay     = r_delay;
        n_prod      = r_prod;
        n_dl        = r_dl;
        n_ret       = r_ret;
        n_pend_st   = r_pend_st;
        n_pend_h    = r_pend_h;
        n_pend_last = r_pend_last;
        w_ord_we    = 1'b0;
        w_ord_waddr = r_i[IW-1:0];
        w_ord_wdata = r_o;
        w_ord_raddr = '0;
        w_dl_we     = 1'b0;
        w_dl_raddr  = w_ord_rdata;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_pend_last = 1'b1;
                n_ret       = S_IDLE;
                n_i         = '0;
                n_found     = 1'b0;
                n_delay     = w_delay;
                n_slot      = w_free_idx;
                n_h         = w_tgt_idx;
                n_is_tick   = (w_cmd == CMD_TICK);
                n_have      = 1'b0;
                n_nexp      = '0;
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_TICK:   n_ctr = r_ctr + TICK_W'(1);
                        CMD_ADD: begin
                            n_pend_st = ST_FULL;
                            n_pend_h  = '0;
                        end
                        CMD_DELETE: begin
                            n_pend_st = w_tgt_ok ? ST_DELETED : ST_NOT_FOUND;
                            n_pend_h  = w_tgt;
                        end
                        CMD_NONE:   n_ctr = r_ctr;
                    endcase
                end
            end
            S_EMIT: ;
            S_MUL:  n_prod = PROD_W'(r_delay) * PROD_W'(r_rate);
            S_DGO:  w_div_start = 1'b1;
            S_DIV:  ;
            S_SUM: begin
                n_dl    = w_sum[TICK_W] ? '1 : w_sum[TICK_W-1:0];
                w_dl_we = 1'b1;
                n_i     = r_count;
            end
            S_ARD:  w_ord_raddr = IW'(r_i - CW'(1));
            S_AORD: n_o = w_ord_rdata;
            S_ACMP: begin
                if (w_dl_rdata > r_dl) begin
                    w_ord_we = 1'b1;
                    n_i      = r_i - CW'(1);
                end
            end
            S_AINS: begin
                w_ord_we         = 1'b1;
                w_ord_wdata      = r_slot;
                n_count          = r_count + CW'(1);
                n_in_use[r_slot] = 1'b1;
                n_pend_st        = ST_ADDED;
                n_pend_h         = HANDLE_W'(r_slot);
            end
            S_RRD:  w_ord_raddr = r_i[IW-1:0];
            S_RCHK: begin
                w_ord_waddr = IW'(r_i - CW'(1));
                w_ord_wdata = w_ord_rdata;
                w_ord_we    = r_found;
                if (w_ord_rdata == r_h) n_found = 1'b1;
                n_i = r_i + CW'(1);
            end
            S_REND: begin
                n_count       = r_count - CW'(1);
                n_in_use[r_h] = 1'b0;
                n_ret         = S_IDLE;
            end
            S_CHECK: w_ord_raddr = '0;
            S_TORD:  n_h = w_ord_rdata;
            S_TDL: begin
                if (w_dl_rdata <= r_ctr) begin
                    n_pend_st   = ST_EXPIRED;
                    n_pend_h    = HANDLE_W'(r_hold);
                    n_pend_last = 1'b0;
                    n_ret       = S_RRD;
                    n_hold      = r_h;
                    n_have      = 1'b1;
                    n_nexp      = r_nexp + NEXP_W'(1);
                    n_i         = '0;
                    n_found     = 1'b0;
                end
            end
            S_FINISH: begin
                n_pend_st   = r_have ? ST_EXPIRED : ST_NONE;
                n_pend_h    = r_have ? HANDLE_W'(r_hold) : '0;
                n_pend_last = 1'b1;
                n_ret       = S_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_ctr       <= '0;
            r_count     <= '0;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ctr    <= n_ctr;
            r_count  <= n_count;
            r_in_use <= n_in_use;
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_found     <= n_found;
        r_h         <= n_h;
        r_o         <= n_o;
        r_slot      <= n_slot;
        r_hold      <= n_hold;
        r_have      <= n_have;
        r_is_tick   <= n_is_tick;
        r_nexp      <= n_nexp;
        r_delay     <= n_delay;
        r_prod      <= n_prod;
        r_dl        <= n_dl;
        r_ret       <= n_ret;
        r_pend_st   <= n_pend_st;
        r_pend_h    <= n_pend_h;
        r_pend_last <= n_pend_last;
        if (r_state == S_EMIT && w_out_free) begin
            r_out_st   <= r_pend_st;
            r_out_h    <= r_pend_h;
            r_out_tick <= r_ctr;
            r_out_last <= r_pend_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out_tick, r_out_h};
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tlast  = r_out_last;
endmodule

// ===== sv/sdtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module sdtq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/sdtq_div.sv =====
// Divider by the milliseconds-per-second constant, one 17-bit digit per cycle.
// Depends on sdtq_pkg; each digit uses a reciprocal multiply and a compare-free remainder.
module sdtq_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sdtq_pkg::PROD_W-1:0] i_num,
    output logic                       o_done,
    output logic [sdtq_pkg::PROD_W-1:0] o_quot
);
    import sdtq_pkg::*;

    localparam int unsigned DIG_W  = 17;
    localparam int unsigned N_DIG  = 3;
    localparam int unsigned NUM_W  = DIG_W * N_DIG;
    localparam int unsigned X_W    = REM_W + DIG_W;
    localparam int unsigned RCP_W  = 28;
    localparam int unsigned RCP_SH = 37;
    localparam int unsigned MUL_W  = X_W + RCP_W;
    localparam int unsigned CNT_W  = 2;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(137438954);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_num;
    logic [REM_W-1:0]  r_rem;
    logic [X_W-1:0]    w_x;
    logic [MUL_W-1:0]  w_prod;
    logic [DIG_W-1:0]  w_q;
    logic [X_W-1:0]    w_r;

    // partial dividend stays below 1000 * 2^17, where the reciprocal is exact
    assign w_x    = {r_rem, r_num[NUM_W-1 -: DIG_W]};
    assign w_prod = MUL_W'(w_x) * MUL_W'(RCP);
    assign w_q    = w_prod[RCP_SH +: DIG_W];
    assign w_r    = w_x - X_W'(w_q) * X_W'(MS_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_DIG);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'(i_num);
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-DIG_W-1:0], w_q};
            r_rem <= w_r[REM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[PROD_W-1:0];
endmodule
